### design/gcdl_pkg.sv
// Shared types and constants for the gcd/lcm unit.
// Used by gcdl_ctrl and gcd_lcm_unit_core; depends on nothing.

package gcdl_pkg;

  localparam int GCD_W = 16;
  localparam int LCM_W = 32;

  // gcd reported when either operand is zero
  localparam logic [GCD_W-1:0] GCD_ZERO = 16'd1;

  typedef struct packed {
    logic [15:0] operand_a;
    logic [15:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [GCD_W-1:0] gcd_value;
    logic [LCM_W-1:0] lcm_value;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_REDUCE,
    ST_DIVIDE,
    ST_MULT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOAD_ZERO,
    OP_HALVE_BOTH,
    OP_HALVE_A,
    OP_HALVE_B,
    OP_SWAP,
    OP_SUB,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_MUL
  } op_t;

  typedef struct packed {
    op_t  op;
    logic busy;
    logic div_sel;
  } ctrl_t;

  typedef struct packed {
    logic in_zero;
    logic a_zero;
    logic a_odd;
    logic b_odd;
    logic borrow;
    logic cnt_last;
  } stat_t;

endpackage

### design/gcdl_ctrl.sv
// Sequencer for the gcd/lcm unit: binary gcd, restoring divide, multiply.
// Depends on gcdl_pkg; drives the datapath in gcd_lcm_unit_core.

module gcdl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  gcdl_pkg::stat_t stat,
  output gcdl_pkg::ctrl_t ctrl
);

  gcdl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcdl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gcdl_pkg::ST_IDLE: begin
        if (start && !stat.in_zero) begin
          state_nxt = gcdl_pkg::ST_TWOS;
        end
      end
      gcdl_pkg::ST_TWOS: begin
        if (stat.a_odd || stat.b_odd) begin
          state_nxt = gcdl_pkg::ST_REDUCE;
        end
      end
      gcdl_pkg::ST_REDUCE: begin
        if (stat.a_zero) begin
          state_nxt = gcdl_pkg::ST_DIVIDE;
        end
      end
      gcdl_pkg::ST_DIVIDE: begin
        if (stat.cnt_last) begin
          state_nxt = gcdl_pkg::ST_MULT;
        end
      end
      gcdl_pkg::ST_MULT: state_nxt = gcdl_pkg::ST_IDLE;
      default: state_nxt = gcdl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op      = gcdl_pkg::OP_NONE;
    ctrl.busy    = (state_r != gcdl_pkg::ST_IDLE);
    ctrl.div_sel = (state_r == gcdl_pkg::ST_DIVIDE);
    unique case (state_r)
      gcdl_pkg::ST_IDLE: begin
        priority if (!start) begin
          ctrl.op = gcdl_pkg::OP_NONE;
        end else if (stat.in_zero) begin
          ctrl.op = gcdl_pkg::OP_LOAD_ZERO;
        end else begin
          ctrl.op = gcdl_pkg::OP_LOAD;
        end
      end
      gcdl_pkg::ST_TWOS: begin
        // strip common factors of two, counted in k
        if (!(stat.a_odd || stat.b_odd)) begin
          ctrl.op = gcdl_pkg::OP_HALVE_BOTH;
        end
      end
      gcdl_pkg::ST_REDUCE: begin
        priority if (stat.a_zero) begin
          ctrl.op = gcdl_pkg::OP_DIV_START;
        end else if (!stat.a_odd) begin
          ctrl.op = gcdl_pkg::OP_HALVE_A;
        end else if (!stat.b_odd) begin
          ctrl.op = gcdl_pkg::OP_HALVE_B;
        end else if (stat.borrow) begin
          ctrl.op = gcdl_pkg::OP_SWAP;
        end else begin
          ctrl.op = gcdl_pkg::OP_SUB;
        end
      end
      gcdl_pkg::ST_DIVIDE: ctrl.op = gcdl_pkg::OP_DIV_STEP;
      gcdl_pkg::ST_MULT:   ctrl.op = gcdl_pkg::OP_MUL;
      default:             ctrl.op = gcdl_pkg::OP_NONE;
    endcase
  end

endmodule

### design/gcd_lcm_unit_core.sv
// Top level of the gcd/lcm unit: datapath, shared subtractor and result register.
// Depends on gcdl_pkg and gcdl_ctrl.

// One operand pair is taken when start is high and busy is low; busy then stays
// high until the result is ready, and the result appears on out_data for exactly
// one cycle with out_valid high. The receiver cannot stall, so capture it then.
// A pair with a zero operand gives gcd 1 and lcm 0 in the cycle after it is
// taken, without raising busy. Otherwise a binary gcd runs on one shared
// subtractor (common halving, then halve/swap/subtract steps), the same
// subtractor then does a restoring divide of operand_a by the gcd, and a
// multiply forms the lcm. The time an item takes is set by the number of gcd
// steps the operands need. The next pair may be started in the cycle the
// result is shown.

module gcd_lcm_unit_core #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  gcdl_pkg::in_t  in_data,
  output logic           out_valid,
  output gcdl_pkg::out_t out_data
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = (W > 2) ? $clog2(W) : 1;
  localparam int PW = 2 * W;

  gcdl_pkg::ctrl_t ctrl;
  gcdl_pkg::stat_t stat;

  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt, rem_r, rem_nxt;
  logic [W-1:0]  opa_r, opa_nxt, opb_r, opb_nxt;
  logic [CW-1:0] k_r, k_nxt, cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  gcdl_pkg::out_t out_r, out_nxt;

  logic [W+15:0] ina_ext, inb_ext;
  logic [W-1:0]  in_a, in_b;
  logic [W:0]    rem_sh;
  logic [W+1:0]  sub_x, sub_y, diff;
  logic [PW-1:0] prod;
  logic [PW+gcdl_pkg::LCM_W-1:0] prod_ext;
  logic [W+gcdl_pkg::GCD_W-1:0]  gcd_ext;

  // mask operands to the configured width
  assign ina_ext = {{W{1'b0}}, in_data.operand_a};
  assign inb_ext = {{W{1'b0}}, in_data.operand_b};
  assign in_a    = ina_ext[W-1:0];
  assign in_b    = inb_ext[W-1:0];

  // shared subtractor: a - b during the gcd, shifted remainder - gcd during divide
  assign rem_sh = {rem_r, a_r[W-1]};
  assign sub_x  = ctrl.div_sel ? {1'b0, rem_sh} : {2'b00, a_r};
  assign sub_y  = {2'b00, b_r};
  assign diff   = sub_x - sub_y;

  assign prod     = PW'(a_r) * PW'(opb_r);
  assign prod_ext = {{gcdl_pkg::LCM_W{1'b0}}, prod};
  assign gcd_ext  = {{gcdl_pkg::GCD_W{1'b0}}, b_r};

  assign stat.in_zero  = (in_a == '0) || (in_b == '0);
  assign stat.a_zero   = (a_r == '0);
  assign stat.a_odd    = a_r[0];
  assign stat.b_odd    = b_r[0];
  assign stat.borrow   = diff[W+1];
  assign stat.cnt_last = (cnt_r == CW'(W - 1));

  gcdl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  always_comb begin
    a_nxt         = a_r;
    b_nxt         = b_r;
    rem_nxt       = rem_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    unique case (ctrl.op)
      gcdl_pkg::OP_NONE: begin
      end
      gcdl_pkg::OP_LOAD: begin
        a_nxt   = in_a;
        b_nxt   = in_b;
        opa_nxt = in_a;
        opb_nxt = in_b;
        k_nxt   = '0;
      end
      gcdl_pkg::OP_LOAD_ZERO: begin
        out_nxt.gcd_value = gcdl_pkg::GCD_ZERO;
        out_nxt.lcm_value = '0;
        out_valid_nxt     = 1'b1;
      end
      gcdl_pkg::OP_HALVE_BOTH: begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + CW'(1);
      end
      gcdl_pkg::OP_HALVE_A: a_nxt = a_r >> 1;
      gcdl_pkg::OP_HALVE_B: b_nxt = b_r >> 1;
      gcdl_pkg::OP_SWAP: begin
        a_nxt = b_r;
        b_nxt = a_r;
      end
      gcdl_pkg::OP_SUB: a_nxt = diff[W-1:0];
      gcdl_pkg::OP_DIV_START: begin
        // restore the common twos; a becomes the dividend
        b_nxt   = b_r << k_r;
        a_nxt   = opa_r;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      gcdl_pkg::OP_DIV_STEP: begin
        a_nxt   = {a_r[W-2:0], ~diff[W+1]};
        rem_nxt = diff[W+1] ? rem_sh[W-1:0] : diff[W-1:0];
        cnt_nxt = cnt_r + CW'(1);
      end
      gcdl_pkg::OP_MUL: begin
        out_nxt.gcd_value = gcd_ext[gcdl_pkg::GCD_W-1:0];
        out_nxt.lcm_value = prod_ext[gcdl_pkg::LCM_W-1:0];
        out_valid_nxt     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  assign busy      = ctrl.busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.gcd_value != '0))
    else $error("gcd result of zero");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !stat.in_zero) |=> busy)
    else $error("nonzero operands taken without going busy");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_sel |-> (b_r != '0))
    else $error("divide step with zero divisor");

endmodule
